@@ rtl/binary_image_thinning_assert.svh @@
// Assertion macros shared by the binary image thinning RTL.
`ifndef BINARY_IMAGE_THINNING_ASSERT_SVH
`define BINARY_IMAGE_THINNING_ASSERT_SVH

// Condition must never hold outside reset.
`define BTHIN_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define BTHIN_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ rtl/bthin_pkg.sv @@
// Shared constants, state encoding and controller/datapath interface types.
package bthin_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ROW_AW   = $clog2(MAX_ROWS);
  localparam int CNT_W    = ROW_AW + 1;
  localparam int CFG_W    = 7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_THIN_RD,
    ST_THIN_DRAIN,
    ST_THIN_DECIDE,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  typedef struct packed {
    logic              load_wr;
    logic              rd_en;
    logic              thin_rd;
    logic              second;
    logic              clr_changed;
    logic              out_load;
    logic              out_final;
    logic [ROW_AW-1:0] addr;
  } cmd_t;

  typedef struct packed {
    logic changed;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/bthin_ctrl.sv @@
// Sequencer for row loading, thinning sweeps and row emission.
module bthin_ctrl
  import bthin_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  input  logic in_tlast,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] rows_r, rows_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             second_r, second_nxt;
  logic             at_end;
  logic             has_room;

  assign at_end   = (idx_r == rows_r - CNT_W'(1));
  assign has_room = (rows_r < CNT_W'(MAX_ROWS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rows_r   <= '0;
      idx_r    <= '0;
      second_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rows_r   <= rows_nxt;
      idx_r    <= idx_nxt;
      second_r <= second_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    rows_nxt   = rows_r;
    idx_nxt    = idx_r;
    second_nxt = second_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (has_room) begin
            rows_nxt = rows_r + CNT_W'(1);
          end
          if (in_tlast) begin
            idx_nxt    = '0;
            second_nxt = 1'b0;
            state_nxt  = ST_THIN_RD;
          end
        end
      end
      ST_THIN_RD: begin
        if (at_end) begin
          state_nxt = ST_THIN_DRAIN;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      ST_THIN_DRAIN: begin
        state_nxt = ST_THIN_DECIDE;
      end
      ST_THIN_DECIDE: begin
        idx_nxt = '0;
        if (!second_r) begin
          second_nxt = 1'b1;
          state_nxt  = ST_THIN_RD;
        end else if (sts.changed) begin
          second_nxt = 1'b0;
          state_nxt  = ST_THIN_RD;
        end else begin
          state_nxt = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        if (sts.out_free) begin
          state_nxt = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD: begin
        if (at_end) begin
          rows_nxt  = '0;
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = ST_EMIT_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready       = 1'b0;
    cmd             = '0;
    cmd.second      = second_r;
    cmd.addr        = idx_r[ROW_AW-1:0];
    case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.addr    = rows_r[ROW_AW-1:0];
        cmd.load_wr = in_tvalid && has_room;
        cmd.clr_changed = in_tvalid && in_tlast;
      end
      ST_THIN_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.thin_rd = 1'b1;
      end
      ST_THIN_DRAIN: begin
      end
      ST_THIN_DECIDE: begin
        cmd.clr_changed = second_r;
      end
      ST_EMIT_RD: begin
        cmd.rd_en = 1'b1;
      end
      ST_EMIT_LD: begin
        cmd.out_load  = 1'b1;
        cmd.out_final = at_end;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/bthin_dp.sv @@
// Row store, neighborhood window, deletion lanes and output register.
module bthin_dp
  import bthin_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [CFG_W-1:0]    cfg_wr_data,
  input  logic [MAX_COLS-1:0] in_tdata,
  input  cmd_t                cmd,
  output sts_t                sts,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [MAX_COLS-1:0] out_tdata,
  output logic                out_tlast
);

  function automatic logic [MAX_COLS-1:0] valid_cols(input logic [CFG_W-1:0] w);
    logic [MAX_COLS-1:0] m;
    for (int j = 0; j < MAX_COLS; j++) begin
      m[j] = (j < int'(w));
    end
    return m;
  endfunction

  function automatic logic [MAX_COLS-1:0] inner_cols(input logic [CFG_W-1:0] w);
    logic [MAX_COLS-1:0] m;
    for (int j = 0; j < MAX_COLS; j++) begin
      m[j] = (j >= 1) && (j + 1 < int'(w));
    end
    return m;
  endfunction

  function automatic logic zs_del(input logic [7:0] p, input logic second);
    logic [3:0] a;
    logic [3:0] b;
    logic       m1;
    logic       m2;
    a = '0;
    b = '0;
    for (int k = 0; k < 8; k++) begin
      b = b + 4'(p[k]);
      if (!p[k] && p[(k + 1) & 7]) begin
        a = a + 4'd1;
      end
    end
    if (second) begin
      m1 = p[0] & p[2] & p[6];
      m2 = p[0] & p[4] & p[6];
    end else begin
      m1 = p[0] & p[2] & p[4];
      m2 = p[2] & p[4] & p[6];
    end
    return (a == 4'd1) && (b >= 4'd2) && (b <= 4'd6) && !m1 && !m2;
  endfunction

  logic [MAX_COLS-1:0] mem [MAX_ROWS];
  logic [MAX_COLS-1:0] mask_r;
  logic [MAX_COLS-1:0] inner_r;
  logic [MAX_COLS-1:0] rd_data_r;
  logic                thin_vld_r;
  logic [ROW_AW-1:0]   rd_idx_r;
  logic [MAX_COLS-1:0] up_r;
  logic [MAX_COLS-1:0] cur_r;
  logic                changed_r;
  logic                out_valid_r;
  logic [MAX_COLS-1:0] out_data_r;
  logic                out_last_r;

  logic [CFG_W-1:0]    w_eff;
  logic [MAX_COLS-1:0] dat;
  logic [MAX_COLS+1:0] up_x;
  logic [MAX_COLS+1:0] cur_x;
  logic [MAX_COLS+1:0] dn_x;
  logic [MAX_COLS-1:0] del;
  logic                thin_wr;

  assign w_eff = (cfg_wr_data > CFG_W'(MAX_COLS)) ? CFG_W'(MAX_COLS) : cfg_wr_data;
  assign dat   = rd_data_r & mask_r;
  assign up_x  = {1'b0, up_r, 1'b0};
  assign cur_x = {1'b0, cur_r, 1'b0};
  assign dn_x  = {1'b0, dat, 1'b0};

  always_comb begin
    for (int j = 0; j < MAX_COLS; j++) begin
      del[j] = cur_r[j] & inner_r[j] & zs_del({up_x[j], cur_x[j], dn_x[j], dn_x[j + 1],
                                               dn_x[j + 2], cur_x[j + 2], up_x[j + 2],
                                               up_x[j + 1]}, cmd.second);
    end
  end

  assign thin_wr = thin_vld_r && (rd_idx_r >= ROW_AW'(2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r  <= valid_cols(CFG_W'(MAX_COLS));
      inner_r <= inner_cols(CFG_W'(MAX_COLS));
    end else if (cfg_wr_en) begin
      mask_r  <= valid_cols(w_eff);
      inner_r <= inner_cols(w_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      mem[cmd.addr] <= in_tdata & mask_r;
    end else if (thin_wr) begin
      mem[rd_idx_r - ROW_AW'(1)] <= cur_r & ~del;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[cmd.addr];
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= cmd.addr;
    if (thin_vld_r) begin
      up_r  <= cur_r;
      cur_r <= dat;
    end
    if (cmd.out_load) begin
      out_data_r <= dat;
      out_last_r <= cmd.out_final;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thin_vld_r  <= 1'b0;
      changed_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      thin_vld_r <= cmd.rd_en && cmd.thin_rd;
      if (cmd.clr_changed) begin
        changed_r <= 1'b0;
      end else if (thin_wr && (|del)) begin
        changed_r <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.changed  = changed_r;
  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tlast    = out_last_r;

endmodule

@@ rtl/binary_image_thinning.sv @@
// Top level of the binary image thinning block.
// Usage:
//   in_* takes one image row per item: tdata bit j is column j, tlast marks the
//   final row. Rows load one per cycle into a 64-row store; rows past the 64th
//   are dropped, but their tlast still starts thinning.
//   cfg_wr_en/cfg_wr_data set the image width (reset 64, values above 64 act as 64).
//   Write it only while no image is in flight.
//   After the last row, thinning runs passes of two subiterations over n rows;
//   each subiteration is one sweep through the row store, one read and one
//   write-back per cycle, then a drain state and a decide state; passes repeat
//   until a pass deletes nothing.
//   out_* then returns the n thinned rows in order, tlast on the final row; each
//   row takes a store read state and then an output register load state.
//   in_tready is low from the last row until the final row enters the output
//   register; the next image may load while that row still waits.
//   A stalled out_tready holds the output register and pauses emission.
//   Reset (rst_n low, synchronous) empties the store and restores width 64.
`include "binary_image_thinning_assert.svh"

module binary_image_thinning
  import bthin_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [CFG_W-1:0]    cfg_wr_data,   // image_width
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [MAX_COLS-1:0] in_tdata,      // row_pixels
  input  logic                in_tlast,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [MAX_COLS-1:0] out_tdata,     // thinned_row
  output logic                out_tlast
);

  cmd_t cmd;
  sts_t sts;

  bthin_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bthin_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .cmd         (cmd),
    .sts         (sts),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  `BTHIN_ASSERT_NEVER(a_no_wr_rd, cmd.load_wr && cmd.rd_en, "row load during store read")
  `BTHIN_ASSERT_IMPLY(a_load_empty, cmd.out_load, !out_tvalid,
                      "output register overwritten while full")
  `BTHIN_ASSERT_IMPLY(a_mid_busy, out_tvalid && !out_tlast, !in_tready,
                      "input open during emission")

endmodule
